### rtl/core/slot_store_min_max_average_macros.svh
// Assertion macros used by the slot store top level.
// Depends on nothing; included by the files that carry assertions.
`ifndef SLOT_STORE_MIN_MAX_AVERAGE_MACROS_SVH
`define SLOT_STORE_MIN_MAX_AVERAGE_MACROS_SVH

`ifndef ASSERT_OFF
// property checked outside reset
`define SSMMA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// property checked on every edge, reset included
`define SSMMA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SSMMA_ASSERT(lbl, clk, rstn, prop, msg)
`define SSMMA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/core/ssmma_pkg.sv
// Types and constants of the slot store with min / max / mean statistics.
// Depends on nothing; imported by the top level.
package ssmma_pkg;

    localparam int unsigned SLOTS_DEFAULT = 16;
    localparam int unsigned SLOT_W        = 6;
    localparam int unsigned VALUE_W       = 32;
    localparam int unsigned COUNT_W       = 7;

    // access kind codes
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef struct packed {
        logic                      kind;
        logic [SLOT_W-1:0]         slot;
        logic signed [VALUE_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        logic                      read_valid;
        logic                      range_error;
        logic signed [VALUE_W-1:0] min_value;
        logic signed [VALUE_W-1:0] max_value;
        logic signed [VALUE_W-1:0] avg_value;
        logic [COUNT_W-1:0]        valid_count;
        logic                      none_valid;
    } out_word_t;

endpackage

### rtl/core/slot_store_min_max_average.sv
// Each accepted word passes the slot access, a scan of all slots (one slot a cycle) and the
// bit-serial divider before its result word; the divider is skipped when no slot holds a
// value. One word is in work at a time; a new word
// is taken while the previous result still waits in the output register.
// Reset (aresetn low, synchronous) empties every slot and drops m_valid.
// Slot store top: FSM, valid bits, scan accumulator; uses ssmma_pkg, ssmma_mem, ssmma_div.
`include "slot_store_min_max_average_macros.svh"

module slot_store_min_max_average import ssmma_pkg::*; #(
    parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CW = $clog2(SLOTS + 1);
    localparam int unsigned SW = VALUE_W + CW;
    localparam logic [CW-1:0]     SLOTS_C    = CW'(SLOTS);
    localparam logic [SLOT_W:0]   SLOT_LIMIT = (SLOT_W + 1)'(SLOTS);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_RDATA = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t                    state_reg, state_next;
    logic                      kind_reg, kind_next;
    logic                      bad_reg, bad_next;
    logic [AW-1:0]             slot_reg, slot_next;
    logic signed [VALUE_W-1:0] rd_value_reg, rd_value_next;
    logic                      rd_ok_reg, rd_ok_next;
    logic [CW-1:0]             scan_idx_reg, scan_idx_next;
    logic                      tap_vld_reg, tap_vld_next;
    logic [AW-1:0]             tap_idx_reg, tap_idx_next;
    logic [CW-1:0]             count_reg, count_next;
    logic signed [SW-1:0]      sum_reg, sum_next;
    logic signed [VALUE_W-1:0] min_reg, min_next;
    logic signed [VALUE_W-1:0] max_reg, max_next;
    logic signed [VALUE_W-1:0] avg_reg, avg_next;
    logic [SLOTS-1:0]          filled_reg;
    logic                      m_valid_reg;
    out_word_t                 m_data_reg;

    logic                      in_bad;
    logic [AW-1:0]             in_addr;
    logic                      fill_en;
    logic                      load_out;
    logic                      mem_wr_en;
    logic                      mem_rd_en;
    logic [AW-1:0]             mem_rd_addr;
    logic [VALUE_W-1:0]        mem_rd_data;
    logic signed [VALUE_W-1:0] tap_x;
    logic                      div_start;
    logic                      div_busy;
    logic                      div_done;
    logic [SW-1:0]             div_num;
    logic [SW-1:0]             div_quo;
    logic [VALUE_W-1:0]        quo_low;

    assign in_bad  = ({1'b0, s_data.slot} >= SLOT_LIMIT);
    assign in_addr = s_data.slot[AW-1:0];
    assign tap_x   = signed'(mem_rd_data);
    assign div_num = sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);
    assign quo_low = div_quo[VALUE_W-1:0];
    assign s_ready = (state_reg == ST_IDLE);

    ssmma_mem #(
        .DEPTH  (SLOTS),
        .ADDR_W (AW),
        .DATA_W (VALUE_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (in_addr),
        .wr_data (s_data.value),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    ssmma_div #(
        .NUM_W (SW),
        .DEN_W (CW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (count_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // sequencer: access, scan of all slots, divide (skipped when no slot is filled), hand over
    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        bad_next      = bad_reg;
        slot_next     = slot_reg;
        rd_value_next = rd_value_reg;
        rd_ok_next    = rd_ok_reg;
        scan_idx_next = scan_idx_reg;
        tap_vld_next  = tap_vld_reg;
        tap_idx_next  = tap_idx_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        avg_next      = avg_reg;
        fill_en       = 1'b0;
        load_out      = 1'b0;
        mem_wr_en     = 1'b0;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = in_addr;
        div_start     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    kind_next  = s_data.kind;
                    bad_next   = in_bad;
                    slot_next  = in_addr;
                    if (!in_bad) begin
                        if (s_data.kind == KIND_WRITE) begin
                            mem_wr_en = 1'b1;
                            fill_en   = 1'b1;
                        end else begin
                            mem_rd_en = 1'b1;
                        end
                    end
                    state_next = ST_RDATA;
                end
            end
            ST_RDATA: begin
                // read data of the accessed slot is on the memory output now
                rd_ok_next    = (kind_reg == KIND_READ) && !bad_reg && filled_reg[slot_reg];
                rd_value_next = rd_ok_next ? signed'(mem_rd_data) : '0;
                scan_idx_next = '0;
                tap_vld_next  = 1'b0;
                count_next    = '0;
                sum_next      = '0;
                min_next      = '0;
                max_next      = '0;
                state_next    = ST_SCAN;
            end
            ST_SCAN: begin
                // issue one slot read per cycle
                tap_vld_next = 1'b0;
                if (scan_idx_reg != SLOTS_C) begin
                    mem_rd_en     = 1'b1;
                    mem_rd_addr   = scan_idx_reg[AW-1:0];
                    tap_vld_next  = 1'b1;
                    tap_idx_next  = scan_idx_reg[AW-1:0];
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                // fold the slot whose data arrived
                if (tap_vld_reg && filled_reg[tap_idx_reg]) begin
                    count_next = count_reg + 1'b1;
                    sum_next   = sum_reg + SW'(tap_x);
                    if ((count_reg == '0) || (tap_x < min_reg)) begin
                        min_next = tap_x;
                    end
                    if ((count_reg == '0) || (tap_x > max_reg)) begin
                        max_next = tap_x;
                    end
                end
                // scan drained
                if (!tap_vld_reg && (scan_idx_reg == SLOTS_C)) begin
                    if (count_reg == '0) begin
                        avg_next   = '0;
                        state_next = ST_DONE;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                // magnitude quotient, sign restored: truncation toward zero
                if (div_done) begin
                    avg_next   = sum_reg[SW-1] ? signed'(-quo_low) : signed'(quo_low);
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            tap_vld_reg <= 1'b0;
            filled_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tap_vld_reg <= tap_vld_next;
            if (fill_en) begin
                filled_reg[in_addr] <= 1'b1;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        bad_reg      <= bad_next;
        slot_reg     <= slot_next;
        rd_value_reg <= rd_value_next;
        rd_ok_reg    <= rd_ok_next;
        scan_idx_reg <= scan_idx_next;
        tap_idx_reg  <= tap_idx_next;
        count_reg    <= count_next;
        sum_reg      <= sum_next;
        min_reg      <= min_next;
        max_reg      <= max_next;
        avg_reg      <= avg_next;
        if (load_out) begin
            m_data_reg.read_value  <= rd_value_reg;
            m_data_reg.read_valid  <= rd_ok_reg;
            m_data_reg.range_error <= bad_reg;
            m_data_reg.min_value   <= min_reg;
            m_data_reg.max_value   <= max_reg;
            m_data_reg.avg_value   <= avg_reg;
            m_data_reg.valid_count <= COUNT_W'(count_reg);
            m_data_reg.none_valid  <= (count_reg == '0);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    `SSMMA_ASSERT(a_accept_to_rdata, aclk, aresetn, (s_valid && s_ready) |=> (state_reg == ST_RDATA), "accepted word did not start the access")
    `SSMMA_ASSERT(a_idle_div_quiet, aclk, aresetn, s_ready |-> !div_busy, "divider busy while taking a new word")
    `SSMMA_ASSERT(a_done_in_div, aclk, aresetn, div_done |-> (state_reg == ST_DIV), "divider finished outside the divide state")
    `SSMMA_ASSERT(a_result_from_done, aclk, aresetn, $rose(m_valid) |-> $past(state_reg == ST_DONE), "result appeared without the hand-over state")
    `SSMMA_ASSERT(a_empty_flag, aclk, aresetn, m_valid |-> (m_data.none_valid == (m_data.valid_count == '0)), "empty flag disagrees with count")
    `SSMMA_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

### rtl/core/ssmma_mem.sv
// Slot value memory: one write port, one read port, registered read data.
// Depends on nothing.
module ssmma_mem #(
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned ADDR_W = 4,
    parameter int unsigned DATA_W = 32
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/ssmma_div.sv
// Restoring divider, unsigned, one quotient bit per cycle.
// Depends on nothing; used by the top level for the mean.
module ssmma_div #(
    parameter int unsigned NUM_W = 37,
    parameter int unsigned DEN_W = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int unsigned ITER_W = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [NUM_W-1:0]  quo_reg;

    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fits;

    // one trial subtraction per cycle; quotient bits shift in as dividend bits shift out
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                iter_reg <= ITER_W'(NUM_W);
            end else if (busy_reg) begin
                iter_reg <= iter_reg - 1'b1;
                if (iter_reg == ITER_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            den_reg <= divisor;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
